// ===== design/lpnd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpnd_pkg: shared types and constants of the length-prefixed name demangler
// Phase and error codes, the result record and sizes of the result queue.
// ----------------------------------------------------------------------------
package lpnd_pkg;

  localparam int LEN_BITS = 16;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_UPPER_D    = 8'h44;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;

  typedef enum logic [2:0] {
    PH_UND   = 3'd0,
    PH_D     = 3'd1,
    PH_START = 3'd2,
    PH_LEN   = 3'd3,
    PH_NAME  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_PREFIX = 3'd1,
    ERR_LENGTH = 3'd2,
    ERR_CUT    = 3'd3,
    ERR_TRAIL  = 3'd4,
    ERR_ZERO   = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       verdict;
    logic       acc;
    err_t       code;
    logic       last;
  } res_t;

endpackage

// ===== design/length_prefixed_name_demangler.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_name_demangler: streaming demangler for _D-prefixed symbols
// Input register, parse step and a four-entry result queue.
// ----------------------------------------------------------------------------
// One symbol byte is taken per request; tlast marks the final byte. The block
// emits each name byte, a dot ahead of every name after the first, and on the
// final byte a verdict (tuser high) with accepted flag and error code. A byte
// passes the input register and the parse step and then sits in the result
// queue until taken. Sustained rate is one byte per cycle while the output side
// takes one result per cycle; a byte that yields two results (a character plus
// the verdict) sends them one after the other through the single output port.
module length_prefixed_name_demangler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_symbol
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [8] accepted, [11:9] error_code
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // is_verdict
);
  import lpnd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       step;
  logic       room2;
  logic [1:0] res_count;
  res_t       res0, res1, out_res;

  assign step     = in_valid && room2;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
    end
  end

  lpnd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .in_byte       (in_byte),
    .end_of_symbol (in_eos),
    .res_count     (res_count),
    .res0          (res0),
    .res1          (res1)
  );

  lpnd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (step ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .room2      (room2),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = {4'd0, out_res.code, out_res.acc, out_res.ch};
  assign m_tlast = out_res.last;
  assign m_tuser = out_res.verdict;

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("verdict not marked last of run");

  a_verdict_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[8] == (m_tdata[11:9] == ERR_NONE)))
    else $error("accepted flag disagrees with error code");

  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[11:8] == 4'd0))
    else $error("character result carries verdict fields");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with empty input register");

endmodule

// ===== design/lpnd_parser.sv =====
// ----------------------------------------------------------------------------
// lpnd_parser: per-byte parse step
// Holds the symbol state and turns one registered byte into up to two results.
// ----------------------------------------------------------------------------
module lpnd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              end_of_symbol,
  output logic [1:0]        res_count,
  output lpnd_pkg::res_t    res0,
  output lpnd_pkg::res_t    res1
);
  import lpnd_pkg::*;

  phase_t              phase, phase_s, phase_next;
  logic [LEN_BITS-1:0] len_acc, len_acc_s, len_acc_next;
  logic [LEN_BITS-1:0] remain, remain_s, remain_next;
  logic                seen, seen_s, seen_next;
  err_t                err, err_s, err_next;

  logic                is_dig;
  logic [3:0]          dig;
  logic [LEN_BITS+3:0] len_mul;
  logic                len_ovf;
  logic                ok;
  logic [LEN_BITS-1:0] rem_dec;

  assign is_dig  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign dig     = 4'(in_byte - CH_ZERO);
  assign len_mul = ({4'd0, len_acc} << 3) + ({4'd0, len_acc} << 1) + (LEN_BITS+4)'(dig);
  assign len_ovf = |len_mul[LEN_BITS+3:LEN_BITS];
  assign ok      = (err == ERR_NONE) && (in_byte != 8'd0);

  // Next state: one parse step, then back to reset values at the symbol end
  always_comb begin
    phase_s   = phase;
    len_acc_s = len_acc;
    remain_s  = remain;
    seen_s    = seen;
    err_s     = err;
    rem_dec   = '0;
    if (err == ERR_NONE) begin
      if (in_byte == 8'd0) begin
        err_s = ERR_ZERO;
      end else begin
        unique case (phase)
          PH_UND: begin
            if (in_byte == CH_UNDERSCORE) phase_s = PH_D;
            else err_s = ERR_PREFIX;
          end
          PH_D: begin
            if (in_byte == CH_UPPER_D) phase_s = PH_START;
            else err_s = ERR_PREFIX;
          end
          PH_START: begin
            if (is_dig) begin
              len_acc_s = LEN_BITS'(dig);
              phase_s   = PH_LEN;
            end else begin
              err_s = seen ? ERR_TRAIL : ERR_LENGTH;
            end
          end
          PH_LEN: begin
            if (is_dig) begin
              if (len_ovf) err_s = ERR_LENGTH;
              else len_acc_s = len_mul[LEN_BITS-1:0];
            end else if (len_acc == '0) begin
              err_s = ERR_LENGTH;
            end else begin
              rem_dec   = len_acc - LEN_BITS'(1);
              remain_s  = rem_dec;
              len_acc_s = '0;
              if (rem_dec == '0) begin
                phase_s = PH_START;
                seen_s  = 1'b1;
              end else begin
                phase_s = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            if (remain == '0) begin
              phase_s = PH_START;
              seen_s  = 1'b1;
            end else begin
              rem_dec  = remain - LEN_BITS'(1);
              remain_s = rem_dec;
              if (rem_dec == '0) begin
                phase_s = PH_START;
                seen_s  = 1'b1;
              end
            end
          end
          default: err_s = ERR_PREFIX;
        endcase
      end
    end

    if (end_of_symbol) begin
      phase_next   = PH_UND;
      len_acc_next = '0;
      remain_next  = '0;
      seen_next    = 1'b0;
      err_next     = ERR_NONE;
    end else begin
      phase_next   = phase_s;
      len_acc_next = len_acc_s;
      remain_next  = remain_s;
      seen_next    = seen_s;
      err_next     = err_s;
    end
  end

  // Outputs: character or dot first, verdict after it
  logic emit_dot, emit_chr, has_char;
  err_t code;
  res_t chr_res, ver_res;

  always_comb begin
    emit_dot = ok && (phase == PH_START) && is_dig && seen;
    emit_chr = ok && (((phase == PH_LEN) && !is_dig && (len_acc != '0)) ||
                      ((phase == PH_NAME) && (remain != '0)));
    has_char = emit_dot || emit_chr;

    code = err_s;
    if (err_s == ERR_NONE) begin
      unique case (phase_s) inside
        PH_UND, PH_D: code = ERR_PREFIX;
        PH_START:     code = seen_s ? ERR_NONE : ERR_LENGTH;
        PH_LEN:       code = (len_acc_s == '0) ? ERR_LENGTH : ERR_CUT;
        PH_NAME:      code = ERR_CUT;
        default:      code = ERR_PREFIX;
      endcase
    end

    chr_res         = '0;
    chr_res.ch      = emit_dot ? CH_DOT : in_byte;
    chr_res.code    = ERR_NONE;
    chr_res.last    = !end_of_symbol;

    ver_res         = '0;
    ver_res.verdict = 1'b1;
    ver_res.acc     = (code == ERR_NONE);
    ver_res.code    = code;
    ver_res.last    = 1'b1;

    res0      = has_char ? chr_res : ver_res;
    res1      = ver_res;
    res_count = 2'(has_char) + 2'(end_of_symbol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_UND;
      len_acc <= '0;
      remain  <= '0;
      seen    <= 1'b0;
      err     <= ERR_NONE;
    end else if (step) begin
      phase   <= phase_next;
      len_acc <= len_acc_next;
      remain  <= remain_next;
      seen    <= seen_next;
      err     <= err_next;
    end
  end

endmodule

// ===== design/lpnd_out_queue.sv =====
// ----------------------------------------------------------------------------
// lpnd_out_queue: small result queue
// Takes up to two results a cycle, hands out one a cycle to the stream side while it is ready.
// ----------------------------------------------------------------------------
module lpnd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  lpnd_pkg::res_t    push0,
  input  lpnd_pkg::res_t    push1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output lpnd_pkg::res_t    out_res
);
  import lpnd_pkg::*;

  res_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] count, count_next;
  logic            pop;
  logic [Q_AW-1:0] wr_ptr1;

  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= Q_CW'(Q_DEPTH - 2));
  assign wr_ptr1   = wr_ptr + Q_AW'(1);

  always_comb begin
    count_next = count + Q_CW'(push_count) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push_count);
      if (pop) rd_ptr <= rd_ptr + Q_AW'(1);
      count <= count_next;
    end
  end

endmodule
